### hw/rtl/atts_pkg.sv
`timescale 1ns / 1ps

package atts_pkg;

  localparam int INTERVAL_W = 20;
  localparam int STREAMS_W  = 8;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INTVL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FLUSHED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_SENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_FAIL  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EARLY_ERR  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RESYNC_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAPID_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ROLE   = 2'd2;

  localparam logic [WORD_W-1:0]  RESYNC_PERIOD_RST = 32'd1000000;
  localparam logic [COUNT_W-1:0] RAPID_LIMIT_RST   = 8'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hFF;

  localparam logic ROLE_HEADSET = 1'b0;

  // first field in the highest bits
  typedef struct packed {
    logic [2:0]            pad;
    logic                  ctlr_read_ok;
    logic [WORD_W-1:0]     ctlr_ts_us;
    logic [WORD_W-1:0]     now_us;
    logic [STREAMS_W-1:0]  streams_sent;
    logic [INTERVAL_W-1:0] interval_us;
  } in_item_t;

  typedef struct packed {
    logic                  pad;
    logic                  flush_scheduled;
    logic                  rapid_alarm;
    logic [COUNT_W-1:0]    rapid_count;
    logic [WORD_W-1:0]     corr_offset_us;
    logic [WORD_W-1:0]     wall_ts_us;
    logic [WORD_W-1:0]     sync_ts_us;
    logic                  publish;
    logic                  frame_ts_attached;
    logic [WORD_W-1:0]     frame_ts_us;
    logic [STATUS_W-1:0]   status;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0]  resync_period_us;
    logic [COUNT_W-1:0] rapid_limit;
    logic               device_role;
  } cfg_t;

  typedef struct packed {
    logic               estimate_valid;
    logic               flush_pending;
    logic [COUNT_W-1:0] rapid_counter;
  } ctl_state_t;

endpackage

### hw/rtl/atts_step.sv
`timescale 1ns / 1ps

module atts_step
  import atts_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  in_item_t              item,
  input  cfg_t                  cfg,
  input  ctl_state_t            ctl,
  input  logic [TIME_WIDTH-1:0] estimate_us,
  input  logic [TIME_WIDTH-1:0] last_ctlr_ts_us,
  input  logic [TIME_WIDTH-1:0] last_correction_us,
  output ctl_state_t            ctl_nxt,
  output logic [TIME_WIDTH-1:0] estimate_us_nxt,
  output logic [TIME_WIDTH-1:0] last_ctlr_ts_us_nxt,
  output logic [TIME_WIDTH-1:0] last_correction_us_nxt,
  output result_t               res
);

  localparam int XW = ((TIME_WIDTH > WORD_W) ? TIME_WIDTH : WORD_W) + 1;

  logic [XW-1:0]         now_x, ctlr_x, intvl_x, period_x, age_x, since_x;
  logic [XW-1:0]         fts_x, sync_x;
  logic [TIME_WIDTH-1:0] now_t, ctlr_t, intvl_t, est_adv, est_work, diff_t;
  logic [TIME_WIDTH-1:0] age_t, since_t;
  logic signed [XW-1:0]  diff_s, half_s;
  logic                  resync, early, abandon;

  always_comb begin
    now_x    = XW'(item.now_us);
    ctlr_x   = XW'(item.ctlr_ts_us);
    intvl_x  = XW'(item.interval_us);
    period_x = XW'(cfg.resync_period_us);
    now_t    = now_x[TIME_WIDTH-1:0];
    ctlr_t   = ctlr_x[TIME_WIDTH-1:0];
    intvl_t  = intvl_x[TIME_WIDTH-1:0];

    est_adv  = estimate_us + intvl_t;
    age_t    = est_adv - last_ctlr_ts_us;
    age_x    = XW'(age_t);
    since_t  = now_t - last_correction_us;
    since_x  = XW'(since_t);
    diff_t   = ctlr_t - est_adv;
    diff_s   = XW'($signed(diff_t));
    half_s   = $signed(XW'(item.interval_us[INTERVAL_W-1:1]));

    ctl_nxt                = ctl;
    estimate_us_nxt        = estimate_us;
    last_ctlr_ts_us_nxt    = last_ctlr_ts_us;
    last_correction_us_nxt = last_correction_us;
    est_work               = est_adv;
    resync                 = 1'b0;
    early                  = 1'b0;
    abandon                = 1'b0;

    res        = '0;
    res.status = ST_OK;
    fts_x      = XW'(est_adv);
    sync_x     = '0;

    if (item.interval_us == '0) begin
      res.status = ST_BAD_INTVL;
      fts_x      = '0;
    end else begin
      estimate_us_nxt = est_adv;
      if (ctl.flush_pending) begin
        ctl_nxt.flush_pending  = 1'b0;
        ctl_nxt.estimate_valid = 1'b0;
        res.status             = ST_FLUSHED;
      end else begin
        res.frame_ts_attached = ctl.estimate_valid;
        if (item.streams_sent == '0) begin
          res.status = ST_NONE_SENT;
        end else begin
          resync = !ctl.estimate_valid || (age_x >= period_x);
          if (resync) begin
            if (!item.ctlr_read_ok) begin
              abandon    = 1'b1;
              res.status = ST_READ_FAIL;
            end else begin
              if (since_x < period_x) begin
                if (ctl.rapid_counter != COUNT_MAX) begin
                  ctl_nxt.rapid_counter = ctl.rapid_counter + 1'b1;
                end
              end else begin
                ctl_nxt.rapid_counter = '0;
              end
              res.corr_offset_us = diff_s[WORD_W-1:0];
              if (diff_s == '0) begin
                ctl_nxt.estimate_valid = 1'b1;
              end else if (diff_s > half_s) begin
                ctl_nxt.estimate_valid = 1'b0;
              end else if (diff_s < -half_s) begin
                ctl_nxt.estimate_valid = 1'b0;
                early                  = 1'b1;
                res.status             = ST_EARLY_ERR;
              end else begin
                ctl_nxt.estimate_valid = (cfg.device_role == ROLE_HEADSET);
              end
              if (!early) begin
                last_ctlr_ts_us_nxt    = ctlr_t;
                estimate_us_nxt        = ctlr_t;
                last_correction_us_nxt = now_t;
                est_work               = ctlr_t;
              end
            end
          end
          if (!abandon && !early) begin
            if (now_t > (est_work + intvl_t)) begin
              ctl_nxt.flush_pending  = 1'b1;
              ctl_nxt.estimate_valid = 1'b0;
            end
            res.publish    = 1'b1;
            sync_x         = XW'(est_work);
            res.wall_ts_us = now_x[WORD_W-1:0] & fts_mask(now_x);
          end
        end
      end
    end

    res.frame_ts_us     = fts_x[WORD_W-1:0];
    res.sync_ts_us      = sync_x[WORD_W-1:0];
    res.rapid_count     = ctl_nxt.rapid_counter;
    res.rapid_alarm     = (ctl_nxt.rapid_counter > cfg.rapid_limit);
    res.flush_scheduled = ctl_nxt.flush_pending;
  end

  // mask that keeps the low bits of the wall clock after reduction to the time width
  function automatic logic [WORD_W-1:0] fts_mask(input logic [XW-1:0] v);
    logic [XW-1:0] m;
    m = XW'({TIME_WIDTH{1'b1}});
    fts_mask = m[WORD_W-1:0] | {WORD_W{v[XW-1]}};
  endfunction

endmodule

### hw/rtl/audio_tx_timestamp_sync_tracker.sv
`timescale 1ns / 1ps
// Throughput: one frame per cycle unless out_tready stalls; one input
// register, one combinational step, one result register (driving out_tdata),
// with the tracking state updated as the result is loaded.
// Reset (rst_n low, synchronous): pipeline emptied, tracking state cleared to
// zero, configuration back to period 1000000 us, limit 20, headset role.

module audio_tx_timestamp_sync_tracker
  import atts_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // interval_us[19:0], streams_sent[27:20], now_us[59:28], ctlr_ts_us[91:60],
  // ctlr_read_ok[92], zero[95:93]
  input  logic [95:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // status[2:0], frame_ts_us[34:3], frame_ts_attached[35], publish[36],
  // sync_ts_us[68:37], wall_ts_us[100:69], corr_offset_us[132:101],
  // rapid_count[140:133], rapid_alarm[141], flush_scheduled[142], zero[143]
  output logic [143:0]         out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  in_item_t              item_r;
  logic                  item_valid_r;
  result_t               res_r, res_nxt;
  logic                  out_valid_r;
  cfg_t                  cfg_r;
  ctl_state_t            ctl_r, ctl_nxt;
  logic [TIME_WIDTH-1:0] estimate_us_r, estimate_us_nxt;
  logic [TIME_WIDTH-1:0] last_ctlr_ts_us_r, last_ctlr_ts_us_nxt;
  logic [TIME_WIDTH-1:0] last_correction_us_r, last_correction_us_nxt;
  logic                  advance;

  assign advance    = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !item_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign cfg_ready  = 1'b1;

  atts_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .item                   (item_r),
    .cfg                    (cfg_r),
    .ctl                    (ctl_r),
    .estimate_us            (estimate_us_r),
    .last_ctlr_ts_us        (last_ctlr_ts_us_r),
    .last_correction_us     (last_correction_us_r),
    .ctl_nxt                (ctl_nxt),
    .estimate_us_nxt        (estimate_us_nxt),
    .last_ctlr_ts_us_nxt    (last_ctlr_ts_us_nxt),
    .last_correction_us_nxt (last_correction_us_nxt),
    .res                    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r                <= '0;
      estimate_us_r        <= '0;
      last_ctlr_ts_us_r    <= '0;
      last_correction_us_r <= '0;
    end else if (advance) begin
      ctl_r                <= ctl_nxt;
      estimate_us_r        <= estimate_us_nxt;
      last_ctlr_ts_us_r    <= last_ctlr_ts_us_nxt;
      last_correction_us_r <= last_correction_us_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resync_period_us <= RESYNC_PERIOD_RST;
      cfg_r.rapid_limit      <= RAPID_LIMIT_RST;
      cfg_r.device_role      <= ROLE_HEADSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESYNC_PERIOD: cfg_r.resync_period_us <= cfg_data;
        REG_RAPID_LIMIT:   cfg_r.rapid_limit      <= cfg_data[COUNT_W-1:0];
        REG_DEVICE_ROLE:   cfg_r.device_role      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  a_flush_taken: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ctl_r.flush_pending && (item_r.interval_us != '0)
    |=> !ctl_r.flush_pending && !ctl_r.estimate_valid)
    else $error("pending flush not consumed");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ctl_r.rapid_counter == COUNT_MAX)
    |=> (ctl_r.rapid_counter == COUNT_MAX) || (ctl_r.rapid_counter == '0))
    else $error("rapid counter wrapped");

  a_publish_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.publish |-> (res_r.status == ST_OK))
    else $error("publish with non-ok status");

  a_bad_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (item_r.interval_us == '0)
    |=> $stable(estimate_us_r) && $stable(ctl_r))
    else $error("state changed on bad interval");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import atts_pkg::*;
;

  typedef enum {
    FR_BAD_INTERVAL, FR_NONE_SENT, FR_READ_FAIL, FR_ON_TIME, FR_DRIFT,
    FR_LATE, FR_EARLY, FR_AHEAD, FR_WRAP, FR_NOISE
  } frame_kind_t;

  class sync_scoreboard_t;
    logic [WORD_W-1:0]  period_us;
    logic [COUNT_W-1:0] limit;
    bit                 role;
    logic [WORD_W-1:0]  est_us;
    bit                 est_ok;
    bit                 flush_pend;
    logic [WORD_W-1:0]  last_ctlr_us;
    logic [WORD_W-1:0]  last_corr_us;
    logic [COUNT_W-1:0] rapid_cnt;
    result_t            frames_due[$];
    int                 errors;
    int                 frames_seen;

    function new();
      period_us    = RESYNC_PERIOD_RST;
      limit        = RAPID_LIMIT_RST;
      role         = ROLE_HEADSET;
      est_us       = '0;
      est_ok       = 1'b0;
      flush_pend   = 1'b0;
      last_ctlr_us = '0;
      last_corr_us = '0;
      rapid_cnt    = '0;
      errors       = 0;
      frames_seen  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_RESYNC_PERIOD: period_us = data;
        REG_RAPID_LIMIT:   limit = data[COUNT_W-1:0];
        REG_DEVICE_ROLE:   role = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void note_frame(in_item_t it);
      result_t           r;
      logic [WORD_W-1:0] ivl;
      logic [WORD_W-1:0] since;
      int                diff;
      int                half;
      r = '0;
      diff = 0;
      ivl = {12'd0, it.interval_us};
      if (ivl == 0) begin
        r.status = ST_BAD_INTVL;
      end else begin
        est_us = est_us + ivl;
        r.frame_ts_us = est_us;
        if (flush_pend) begin
          flush_pend = 1'b0;
          est_ok = 1'b0;
          r.status = ST_FLUSHED;
        end else begin
          r.frame_ts_attached = est_ok;
          r.status = ST_OK;
          if (it.streams_sent == 0) begin
            r.status = ST_NONE_SENT;
          end else if (!est_ok || (est_us - last_ctlr_us) >= period_us) begin
            if (!it.ctlr_read_ok) begin
              r.status = ST_READ_FAIL;
            end else begin
              half = int'(ivl >> 1);
              since = it.now_us - last_corr_us;
              diff = int'(it.ctlr_ts_us - est_us);
              if (since < period_us) begin
                if (rapid_cnt != COUNT_MAX) rapid_cnt = rapid_cnt + 1'b1;
              end else begin
                rapid_cnt = '0;
              end
              if (diff == 0) begin
                est_ok = 1'b1;
              end else if (diff > half) begin
                est_ok = 1'b0;
              end else if (diff < -half) begin
                est_ok = 1'b0;
                r.status = ST_EARLY_ERR;
                r.corr_offset_us = diff;
              end else begin
                est_ok = (role == ROLE_HEADSET);
              end
              if (r.status == ST_OK) begin
                last_ctlr_us = it.ctlr_ts_us;
                est_us = it.ctlr_ts_us;
                last_corr_us = it.now_us;
              end
            end
          end
          if (r.status == ST_OK) begin
            if (it.now_us > est_us + ivl) begin
              flush_pend = 1'b1;
              est_ok = 1'b0;
            end
            r.publish = 1'b1;
            r.sync_ts_us = est_us;
            r.wall_ts_us = it.now_us;
            r.corr_offset_us = diff;
          end
        end
      end
      r.rapid_count = rapid_cnt;
      r.rapid_alarm = rapid_cnt > limit;
      r.flush_scheduled = flush_pend;
      frames_due.push_back(r);
    endfunction

    task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp);
      if (errors < 40)
        $display("frame %0d %s: got %h, expected %h", frames_seen, what, got, exp);
      errors++;
    endtask

    task cmp(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp);
      if (got !== exp) report(what, got, exp);
    endtask

    task check_frame(result_t got);
      result_t exp;
      frames_seen++;
      if (frames_due.size() == 0) begin
        report("result with nothing outstanding", WORD_W'(got.status), '0);
        return;
      end
      exp = frames_due.pop_front();
      cmp("status", WORD_W'(got.status), WORD_W'(exp.status));
      cmp("frame_ts_us", got.frame_ts_us, exp.frame_ts_us);
      cmp("frame_ts_attached", WORD_W'(got.frame_ts_attached),
          WORD_W'(exp.frame_ts_attached));
      cmp("publish", WORD_W'(got.publish), WORD_W'(exp.publish));
      cmp("sync_ts_us", got.sync_ts_us, exp.sync_ts_us);
      cmp("wall_ts_us", got.wall_ts_us, exp.wall_ts_us);
      cmp("corr_offset_us", got.corr_offset_us, exp.corr_offset_us);
      cmp("rapid_count", WORD_W'(got.rapid_count), WORD_W'(exp.rapid_count));
      cmp("rapid_alarm", WORD_W'(got.rapid_alarm), WORD_W'(exp.rapid_alarm));
      cmp("flush_scheduled", WORD_W'(got.flush_scheduled),
          WORD_W'(exp.flush_scheduled));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // interval_us, streams_sent, now_us, ctlr_ts_us, ctlr_read_ok, zero pad
  logic [95:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  // status, frame_ts_us, frame_ts_attached, publish, sync_ts_us, wall_ts_us,
  // corr_offset_us, rapid_count, rapid_alarm, flush_scheduled, zero pad
  logic [143:0]         out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  sync_scoreboard_t sb;
  int unsigned      base_ivl;

  frame_kind_t dir_kind[22] = '{
    FR_BAD_INTERVAL, FR_READ_FAIL, FR_NONE_SENT, FR_ON_TIME, FR_ON_TIME,
    FR_NONE_SENT, FR_DRIFT, FR_LATE, FR_EARLY, FR_DRIFT, FR_AHEAD,
    FR_ON_TIME, FR_ON_TIME, FR_LATE, FR_WRAP, FR_ON_TIME, FR_EARLY,
    FR_ON_TIME, FR_NOISE, FR_READ_FAIL, FR_BAD_INTERVAL, FR_DRIFT
  };
  logic [INTERVAL_W-1:0] dir_ivl[22] = '{
    20'd0, 20'd1048575, 20'd10000, 20'd10000, 20'd10000, 20'd10000,
    20'd1048575, 20'd1048575, 20'd10000, 20'd10000, 20'd10000, 20'd10000,
    20'd10000, 20'd1, 20'd10000, 20'd10000, 20'd1048575, 20'd1, 20'd0,
    20'd10000, 20'd0, 20'd1
  };

  audio_tx_timestamp_sync_tracker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_frame(in_item_t'(in_tdata));
      if (out_tvalid && out_tready) sb.check_frame(result_t'(out_tdata));
    end
  end

  initial begin
    int mode;
    int len;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(10, 60);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [INTERVAL_W-1:0] pick_interval();
    int w;
    w = $urandom_range(0, 99);
    if (w < 70) return INTERVAL_W'(base_ivl);
    if (w < 80) return INTERVAL_W'($urandom_range(1, 20'hFFFFF));
    if (w < 85) return 20'hFFFFF;
    if (w < 90) return 20'd1;
    return INTERVAL_W'($urandom_range(2, 64));
  endfunction

  function automatic frame_kind_t pick_kind();
    int w;
    w = $urandom_range(0, 99);
    if (w < 25) return FR_ON_TIME;
    if (w < 45) return FR_DRIFT;
    if (w < 53) return FR_LATE;
    if (w < 61) return FR_EARLY;
    if (w < 69) return FR_AHEAD;
    if (w < 74) return FR_NONE_SENT;
    if (w < 79) return FR_READ_FAIL;
    if (w < 83) return FR_BAD_INTERVAL;
    if (w < 87) return FR_WRAP;
    return FR_NOISE;
  endfunction

  function automatic in_item_t build_frame(frame_kind_t kind, logic [INTERVAL_W-1:0] ivl);
    in_item_t          it;
    logic [WORD_W-1:0] adv;
    logic [WORD_W-1:0] half;
    logic [WORD_W-1:0] span;
    it = '0;
    it.interval_us = ivl;
    it.streams_sent = STREAMS_W'($urandom_range(1, 255));
    it.ctlr_read_ok = 1'b1;
    span = {12'd0, ivl};
    half = span >> 1;
    adv = sb.est_us + span;
    it.ctlr_ts_us = adv;
    it.now_us = adv + $urandom_range(0, span);
    case (kind)
      FR_BAD_INTERVAL: begin
        it.interval_us = '0;
        it.now_us = $urandom;
        it.ctlr_ts_us = $urandom;
      end
      FR_NONE_SENT: it.streams_sent = '0;
      FR_READ_FAIL: it.ctlr_read_ok = 1'b0;
      FR_ON_TIME: ;
      FR_DRIFT: it.ctlr_ts_us = adv + $urandom_range(0, 2 * half) - half;
      FR_LATE: it.ctlr_ts_us = adv + half + $urandom_range(1, span);
      FR_EARLY: it.ctlr_ts_us = adv - half - $urandom_range(1, span);
      FR_AHEAD: it.now_us = adv + span + $urandom_range(1, 3 * span);
      FR_WRAP: begin
        it.ctlr_ts_us = 32'hFFFF_FFFF - $urandom_range(0, span);
        it.now_us = it.ctlr_ts_us + $urandom_range(0, 2 * span);
      end
      default: begin
        it.interval_us = INTERVAL_W'($urandom);
        it.streams_sent = STREAMS_W'($urandom);
        it.now_us = $urandom;
        it.ctlr_ts_us = $urandom;
        it.ctlr_read_ok = 1'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic run_frames(int count, bit directed);
    int n;
    int burst;
    int gap;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && n < count; i++) begin
        @(negedge clk);
        if (directed)
          in_tdata <= build_frame(dir_kind[n], dir_ivl[n]);
        else
          in_tdata <= build_frame(pick_kind(), pick_interval());
        in_tvalid <= 1'b1;
        do @(posedge clk); while (!in_tready);
        n++;
      end
      @(negedge clk);
      in_tvalid <= 1'b0;
      gap = $urandom_range(0, 4);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RESYNC_PERIOD;
    cfg_data = '0;
    base_ivl = 10000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_frames(22, 1'b1);
    drain();

    write_reg(REG_RESYNC_PERIOD, 32'd1);
    write_reg(REG_RAPID_LIMIT, 32'd0);
    write_reg(REG_DEVICE_ROLE, 32'd1);
    base_ivl = 7500;
    run_frames(120, 1'b0);
    drain();

    write_reg(REG_RESYNC_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_RAPID_LIMIT, 32'd255);
    base_ivl = 10000;
    run_frames(250, 1'b0);
    drain();
    run_frames(250, 1'b0);
    drain();

    write_reg(REG_RESYNC_PERIOD, 32'd5000);
    write_reg(REG_RAPID_LIMIT, 32'd3);
    write_reg(REG_DEVICE_ROLE, 32'd0);
    base_ivl = 2500;
    run_frames(120, 1'b0);
    drain();

    write_reg(REG_RESYNC_PERIOD, $urandom_range(1, 3000000));
    write_reg(REG_RAPID_LIMIT, $urandom_range(0, 255));
    write_reg(REG_DEVICE_ROLE, $urandom_range(0, 1));
    base_ivl = $urandom_range(1, 20000);
    run_frames(140, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
